// File: rtl/grid_cfl_divergence_max_scan_defines.svh
// Assertion macros used by the top level of the CFL and divergence maximum scan.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef GRID_CFL_DIVERGENCE_MAX_SCAN_DEFINES_SVH
`define GRID_CFL_DIVERGENCE_MAX_SCAN_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/gcdms_pkg.sv
// Types and constants for the CFL and divergence maximum scan.
// Used by the controller, the datapath and the top level; no dependencies.
package gcdms_pkg;

    localparam int W_VEL = 32;
    localparam int W_VAL = 48;
    localparam int W_POS = 11;
    localparam int W_IDX = 3;
    localparam int IN_W  = 224;
    localparam int OUT_W = 88;

    localparam logic [W_VAL-1:0] SAT48 = {W_VAL{1'b1}};

    localparam logic [W_IDX-1:0] REG_MODE      = 3'd0;
    localparam logic [W_IDX-1:0] REG_INV_DX    = 3'd1;
    localparam logic [W_IDX-1:0] REG_INV_DY    = 3'd2;
    localparam logic [W_IDX-1:0] REG_TIME_STEP = 3'd3;
    localparam logic [W_IDX-1:0] REG_LIMIT     = 3'd4;
    localparam logic [W_IDX-1:0] REG_SIZE_X    = 3'd5;
    localparam logic [W_IDX-1:0] REG_SIZE_Y    = 3'd6;
    localparam logic [W_IDX-1:0] REG_SIZE_Z    = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_U,
        S_MUL_V,
        S_MUL_W,
        S_ACC_W,
        S_CMP,
        S_DT_LO,
        S_DT_HI,
        S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        MSEL_U,
        MSEL_V,
        MSEL_W,
        MSEL_DT_LO,
        MSEL_DT_HI
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     acc_clr;
        logic     acc_en;
        logic     cmp;
        logic     dt_save;
        logic     emit;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic mode_div;
        logic out_free;
    } t_dp_status;

endpackage

// File: rtl/gcdms_ctrl.sv
// Sequencing state machine for the CFL and divergence maximum scan.
// Depends on gcdms_pkg; drives the datapath through t_dp_cmd.
module gcdms_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  gcdms_pkg::t_dp_status  i_status,
    output gcdms_pkg::t_dp_cmd     o_cmd
);
    import gcdms_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_MUL_U;
                end
            end
            S_MUL_U: n_state = S_MUL_V;
            S_MUL_V: n_state = S_MUL_W;
            S_MUL_W: n_state = S_ACC_W;
            S_ACC_W: n_state = S_CMP;
            S_CMP: begin
                if (!i_status.last) begin
                    n_state = S_IDLE;
                end else if (i_status.mode_div) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_DT_LO;
                end
            end
            S_DT_LO: n_state = S_DT_HI;
            S_DT_HI: n_state = S_EMIT;
            S_EMIT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready    = 1'b0;
        o_cmd         = '0;
        o_cmd.mul_sel = MSEL_U;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            S_MUL_U: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MSEL_U;
                o_cmd.acc_clr = 1'b1;
            end
            S_MUL_V: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MSEL_V;
                o_cmd.acc_en  = 1'b1;
            end
            S_MUL_W: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MSEL_W;
                o_cmd.acc_en  = 1'b1;
            end
            S_ACC_W: begin
                o_cmd.acc_en = 1'b1;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
            end
            S_DT_LO: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MSEL_DT_LO;
            end
            S_DT_HI: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MSEL_DT_HI;
                o_cmd.dt_save = 1'b1;
            end
            S_EMIT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/gcdms_dp.sv
// Datapath of the CFL and divergence maximum scan: registers, shared multiplier,
// accumulator, running maximum, cell position and output register. Depends on gcdms_pkg.
module gcdms_dp #(
    parameter int MAX_DIM = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [gcdms_pkg::W_IDX-1:0]       i_cfg_index,
    input  logic [gcdms_pkg::W_VAL-1:0]       i_cfg_wdata,
    input  logic [gcdms_pkg::IN_W-1:0]        i_s_tdata,
    input  gcdms_pkg::t_dp_cmd                i_cmd,
    output gcdms_pkg::t_dp_status             o_status,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [gcdms_pkg::OUT_W-1:0]       o_m_tdata
);
    import gcdms_pkg::*;

    localparam int DIM_HI = (MAX_DIM > 2047) ? 2047 : MAX_DIM;
    localparam logic [W_POS-1:0] DIM_HI_V = DIM_HI[W_POS-1:0];
    localparam logic [W_POS-1:0] POS_ONE  = W_POS'(1);

    function automatic logic [W_POS-1:0] eff_size(input logic [W_POS-1:0] s);
        logic [W_POS-1:0] r;
        if (s == '0) begin
            r = POS_ONE;
        end else if (s > DIM_HI_V) begin
            r = DIM_HI_V;
        end else begin
            r = s;
        end
        return r;
    endfunction

    logic                 r_mode;
    logic [W_VEL-1:0]     r_inv_dx;
    logic [W_VEL-1:0]     r_inv_dy;
    logic [W_VEL-1:0]     r_time_step;
    logic [W_VAL-1:0]     r_limit;
    logic [W_POS-1:0]     r_size_x;
    logic [W_POS-1:0]     r_size_y;
    logic [W_POS-1:0]     r_size_z;

    logic [IN_W-1:0]      r_cell;
    logic                 r_cell_div;
    logic [64:0]          r_prod;
    logic                 r_prod_neg;
    logic signed [50:0]   r_acc;
    logic [W_VAL-1:0]     r_dt_lo;
    logic [W_VAL-1:0]     r_best_value;
    logic [W_POS-1:0]     r_best_i;
    logic [W_POS-1:0]     r_best_j;
    logic [W_POS-1:0]     r_best_k;
    logic [W_POS-1:0]     r_pos_i;
    logic [W_POS-1:0]     r_pos_j;
    logic [W_POS-1:0]     r_pos_k;
    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_out_data;

    logic [W_VEL-1:0]     w_a;
    logic [W_VEL-1:0]     w_b;
    logic [W_VEL-1:0]     w_sp;
    logic signed [32:0]   w_pair;
    logic [32:0]          w_pair_mag;
    logic [32:0]          w_mul_a;
    logic [W_VEL-1:0]     w_mul_b;
    logic                 w_mul_neg;
    logic [49:0]          w_term_mag;
    logic signed [50:0]   w_term;
    logic [50:0]          w_acc_mag;
    logic [W_VAL-1:0]     w_metric;
    logic                 w_wi;
    logic                 w_wj;
    logic                 w_wk;
    logic                 w_last;
    logic [48:0]          w_dt_sum;
    logic [W_VAL-1:0]     w_dt;
    logic [W_VAL-1:0]     w_value;
    logic                 w_passed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_inv_dx    <= W_VEL'(65536);
            r_inv_dy    <= W_VEL'(65536);
            r_time_step <= W_VEL'(65536);
            r_limit     <= W_VAL'(65536);
            r_size_x    <= W_POS'(1024);
            r_size_y    <= W_POS'(1024);
            r_size_z    <= W_POS'(1024);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_MODE:      r_mode      <= i_cfg_wdata[0];
                REG_INV_DX:    r_inv_dx    <= i_cfg_wdata[W_VEL-1:0];
                REG_INV_DY:    r_inv_dy    <= i_cfg_wdata[W_VEL-1:0];
                REG_TIME_STEP: r_time_step <= i_cfg_wdata[W_VEL-1:0];
                REG_LIMIT:     r_limit     <= i_cfg_wdata;
                REG_SIZE_X:    r_size_x    <= i_cfg_wdata[W_POS-1:0];
                REG_SIZE_Y:    r_size_y    <= i_cfg_wdata[W_POS-1:0];
                REG_SIZE_Z:    r_size_z    <= i_cfg_wdata[W_POS-1:0];
                default: begin
                    r_mode <= r_mode;
                end
            endcase
        end
    end

    always_comb begin
        case (i_cmd.mul_sel)
            MSEL_V: begin
                w_a  = r_cell[95:64];
                w_b  = r_cell[127:96];
                w_sp = r_inv_dy;
            end
            MSEL_W: begin
                w_a  = r_cell[159:128];
                w_b  = r_cell[191:160];
                w_sp = r_cell[223:192];
            end
            default: begin
                w_a  = r_cell[31:0];
                w_b  = r_cell[63:32];
                w_sp = r_inv_dx;
            end
        endcase
    end

    always_comb begin
        if (r_cell_div) begin
            w_pair = $signed({w_a[31], w_a}) - $signed({w_b[31], w_b});
        end else begin
            w_pair = $signed({w_a[31], w_a}) + $signed({w_b[31], w_b});
        end
        w_pair_mag = w_pair[32] ? 33'(-w_pair) : 33'(w_pair);
        case (i_cmd.mul_sel)
            MSEL_DT_LO: begin
                w_mul_a   = {1'b0, r_best_value[31:0]};
                w_mul_b   = r_time_step;
                w_mul_neg = 1'b0;
            end
            MSEL_DT_HI: begin
                w_mul_a   = {17'b0, r_best_value[47:32]};
                w_mul_b   = r_time_step;
                w_mul_neg = 1'b0;
            end
            default: begin
                w_mul_a   = w_pair_mag;
                w_mul_b   = w_sp;
                w_mul_neg = r_cell_div & w_pair[32];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cell     <= i_s_tdata;
            r_cell_div <= r_mode;
        end
        if (i_cmd.mul_en) begin
            r_prod     <= 65'(w_mul_a) * 65'(w_mul_b);
            r_prod_neg <= w_mul_neg;
        end
        if (i_cmd.dt_save) begin
            r_dt_lo <= r_prod[63:16];
        end
    end

    always_comb begin
        if (r_cell_div) begin
            w_term_mag = 50'(r_prod[64:16]) + 50'(r_prod_neg & (|r_prod[15:0]));
        end else begin
            w_term_mag = 50'(r_prod[64:17]);
        end
        w_term = r_prod_neg ? -$signed({1'b0, w_term_mag}) : $signed({1'b0, w_term_mag});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_en) begin
            r_acc <= r_acc + w_term;
        end
    end

    always_comb begin
        w_acc_mag = r_acc[50] ? 51'(-r_acc) : 51'(r_acc);
        w_metric  = (|w_acc_mag[50:48]) ? SAT48 : w_acc_mag[47:0];
        w_wi      = r_pos_i >= eff_size(r_size_x);
        w_wj      = r_pos_j >= eff_size(r_size_y);
        w_wk      = r_pos_k >= eff_size(r_size_z);
        w_last    = w_wi & w_wj & w_wk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_value <= '0;
            r_best_i     <= POS_ONE;
            r_best_j     <= POS_ONE;
            r_best_k     <= POS_ONE;
            r_pos_i      <= POS_ONE;
            r_pos_j      <= POS_ONE;
            r_pos_k      <= POS_ONE;
        end else if (i_cmd.cmp) begin
            if (w_metric > r_best_value) begin
                r_best_value <= w_metric;
                r_best_i     <= r_pos_i;
                r_best_j     <= r_pos_j;
                r_best_k     <= r_pos_k;
            end
            if (w_last) begin
                r_pos_i <= POS_ONE;
                r_pos_j <= POS_ONE;
                r_pos_k <= POS_ONE;
            end else if (!w_wi) begin
                r_pos_i <= r_pos_i + POS_ONE;
            end else begin
                r_pos_i <= POS_ONE;
                if (!w_wj) begin
                    r_pos_j <= r_pos_j + POS_ONE;
                end else begin
                    r_pos_j <= POS_ONE;
                    r_pos_k <= r_pos_k + POS_ONE;
                end
            end
        end else if (i_cmd.emit) begin
            r_best_value <= '0;
            r_best_i     <= POS_ONE;
            r_best_j     <= POS_ONE;
            r_best_k     <= POS_ONE;
        end
    end

    always_comb begin
        w_dt_sum = 49'({r_prod[31:0], 16'b0}) + 49'(r_dt_lo);
        w_dt     = ((|r_prod[64:32]) || w_dt_sum[48]) ? SAT48 : w_dt_sum[47:0];
        w_value  = r_cell_div ? r_best_value : w_dt;
        w_passed = w_value <= r_limit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= {6'b0, w_passed, r_best_k, r_best_j, r_best_i, w_value};
        end
    end

    assign o_status.last     = w_last;
    assign o_status.mode_div = r_cell_div;
    assign o_status.out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid        = r_out_valid;
    assign o_m_tdata         = r_out_data;

endmodule

// File: rtl/grid_cfl_divergence_max_scan.sv
// Top level of the CFL and divergence maximum scan over a streamed grid.
// Depends on gcdms_pkg, gcdms_ctrl, gcdms_dp and the assertion macro header.
//
// Cells arrive in raster order (i fastest, then j, then k), one transfer per cell.
// Each cell is taken in the idle state; the block is not ready for the next one until
// the three multiply states, the accumulate and the compare have run, as one shared
// 33x32 multiplier forms the three velocity terms in turn. After the last cell of the
// grid, CFL mode adds two multiply states, where the same multiplier scales the maximum
// by the time step in two partial products, before the emit state; divergence mode goes
// straight to emit. The result sits in an output register, so one result may wait while
// the next scan runs; a second final cell stalls until the first result is taken.
`include "grid_cfl_divergence_max_scan_defines.svh"

module grid_cfl_divergence_max_scan #(
    parameter int MAX_DIM = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [gcdms_pkg::W_IDX-1:0]   i_cfg_index,
    input  logic [gcdms_pkg::W_VAL-1:0]   i_cfg_wdata,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // u_here, u_west, v_here, v_south, w_here, w_below, dz_inv (32 bits each)
    input  logic [gcdms_pkg::IN_W-1:0]    i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // max_value (48), max_i (11), max_j (11), max_k (11), passed (1), zero fill (6)
    output logic [gcdms_pkg::OUT_W-1:0]   o_m_axis_tdata
);
    import gcdms_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    gcdms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    gcdms_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .o_m_tdata   (o_m_axis_tdata)
    );

    `ASSERT_NEXT(a_one_cell_in_flight, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)
    `ASSERT_NEXT(a_result_held, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))
    `ASSERT_IMPL(a_position_nonzero, i_clk, i_rst_n, o_m_axis_tvalid, (o_m_axis_tdata[58:48] != '0) && (o_m_axis_tdata[69:59] != '0) && (o_m_axis_tdata[80:70] != '0))

endmodule

// File: bench/tb.sv
// Testbench for grid_cfl_divergence_max_scan: streams directed and random grids of cells
// and checks each reported maximum, its position and the pass flag against a scan model.
// Depends on gcdms_pkg and the RTL of the block; reads no files.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gcdms_pkg::*;

    localparam logic        MODE_CFL   = 1'b0;
    localparam logic        MODE_DIV   = 1'b1;
    localparam int          EXTENT_CAP = 1024;
    localparam logic [31:0] ONE_Q16    = 32'h0001_0000;
    localparam logic [31:0] MAX32      = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0]        dz_inv;
        logic signed [31:0] w_below;
        logic signed [31:0] w_here;
        logic signed [31:0] v_south;
        logic signed [31:0] v_here;
        logic signed [31:0] u_west;
        logic signed [31:0] u_here;
    } cell_t;

    typedef struct packed {
        logic             passed;
        logic [W_POS-1:0] k;
        logic [W_POS-1:0] j;
        logic [W_POS-1:0] i;
        logic [W_VAL-1:0] value;
    } max_report_t;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [W_IDX-1:0] i_cfg_index;
    logic [W_VAL-1:0] i_cfg_wdata;
    logic             i_s_axis_tvalid;
    logic             o_s_axis_tready;
    logic [IN_W-1:0]  i_s_axis_tdata;
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready;
    logic [OUT_W-1:0] o_m_axis_tdata;

    cell_t       cells_to_send[$];
    max_report_t maxima_due[$];
    int          idle_pct;
    logic        squeeze_out;
    logic        squeezed;
    int          hold_cycles;
    int          fail_count;

    logic             cfg_mode;
    logic [31:0]      cfg_inv_dx, cfg_inv_dy, cfg_time_step;
    logic [W_VAL-1:0] cfg_limit;
    logic [W_POS-1:0] cfg_size_x, cfg_size_y, cfg_size_z;
    logic [W_VAL-1:0] best_value;
    logic [W_POS-1:0] best_i, best_j, best_k, pos_i, pos_j, pos_k;

    grid_cfl_divergence_max_scan dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [W_POS-1:0] extent(input logic [W_POS-1:0] s);
        if (s == 0) begin
            return 1;
        end
        if (s > EXTENT_CAP) begin
            return W_POS'(EXTENT_CAP);
        end
        return s;
    endfunction

    function automatic logic [W_VAL-1:0] cfl_term(input logic signed [31:0] a, b,
                                                  input logic [31:0] sp);
        logic [32:0] s;
        logic [32:0] m;
        logic [64:0] p;
        s = {a[31], a} + {b[31], b};
        m = s[32] ? (~s + 1'b1) : s;
        p = m * sp;
        return p[64:17];
    endfunction

    // Rounded toward minus infinity, so a negative remainder pushes one step down.
    function automatic logic signed [49:0] div_term(input logic signed [31:0] a, b,
                                                    input logic [31:0] sp);
        logic [32:0] d;
        logic [32:0] m;
        logic [64:0] p;
        logic [49:0] q;
        d = {a[31], a} - {b[31], b};
        m = d[32] ? (~d + 1'b1) : d;
        p = m * sp;
        q = {1'b0, p[64:16]};
        if (d[32]) begin
            if (p[15:0] != 0) begin
                q = q + 1'b1;
            end
            return -q;
        end
        return q;
    endfunction

    function automatic logic [W_VAL-1:0] cell_metric(input cell_t c, input logic div_mode);
        logic [49:0]        cfl_sum;
        logic signed [51:0] div_sum;
        logic [51:0]        mag;
        if (div_mode == MODE_CFL) begin
            cfl_sum = cfl_term(c.u_here, c.u_west, cfg_inv_dx)
                    + cfl_term(c.v_here, c.v_south, cfg_inv_dy)
                    + cfl_term(c.w_here, c.w_below, c.dz_inv);
            return (cfl_sum > SAT48) ? SAT48 : cfl_sum[W_VAL-1:0];
        end
        div_sum = div_term(c.u_here, c.u_west, cfg_inv_dx)
                + div_term(c.v_here, c.v_south, cfg_inv_dy)
                + div_term(c.w_here, c.w_below, c.dz_inv);
        mag = div_sum[51] ? -div_sum : div_sum;
        return (mag > SAT48) ? SAT48 : mag[W_VAL-1:0];
    endfunction

    function automatic logic [W_VAL-1:0] scale_by_step(input logic [W_VAL-1:0] v,
                                                       input logic [31:0] t);
        logic [79:0] p;
        p = v * t;
        return (p[79:16] > SAT48) ? SAT48 : p[63:16];
    endfunction

    function automatic void restart_scan();
        best_value = '0;
        best_i = 1;
        best_j = 1;
        best_k = 1;
        pos_i = 1;
        pos_j = 1;
        pos_k = 1;
    endfunction

    function automatic void scan_cell(input cell_t c);
        logic [W_VAL-1:0] metric;
        logic [W_VAL-1:0] v;
        logic             wi, wj;
        max_report_t      r;
        metric = cell_metric(c, cfg_mode);
        if (metric > best_value) begin
            best_value = metric;
            best_i = pos_i;
            best_j = pos_j;
            best_k = pos_k;
        end
        wi = pos_i >= extent(cfg_size_x);
        wj = pos_j >= extent(cfg_size_y);
        if (wi && wj && pos_k >= extent(cfg_size_z)) begin
            v = (cfg_mode == MODE_CFL) ? scale_by_step(best_value, cfg_time_step) : best_value;
            r.value = v;
            r.i = best_i;
            r.j = best_j;
            r.k = best_k;
            r.passed = (v <= cfg_limit);
            maxima_due.push_back(r);
            restart_scan();
        end else if (!wi) begin
            pos_i = pos_i + 1'b1;
        end else begin
            pos_i = 1;
            if (!wj) begin
                pos_j = pos_j + 1'b1;
            end else begin
                pos_j = 1;
                pos_k = pos_k + 1'b1;
            end
        end
    endfunction

    function automatic cell_t cell_of(input logic [31:0] uh, uw, vh, vs, wh, wb, dz);
        cell_t c;
        c.u_here = uh;
        c.u_west = uw;
        c.v_here = vh;
        c.v_south = vs;
        c.w_here = wh;
        c.w_below = wb;
        c.dz_inv = dz;
        return c;
    endfunction

    function automatic logic [31:0] pick_velocity();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 3))
            0: r = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            1: r = $signed(r) >>> $urandom_range(8, 31);
            2: r = {r[0], {31{r[1]}}};
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] pick_spacing();
        case ($urandom_range(0, 4))
            0: return ONE_Q16;
            1: return $urandom_range(0, 32'h0010_0000);
            2: return ($urandom_range(0, 1) == 1) ? MAX32 : 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [W_VAL-1:0] pick_limit();
        logic [W_VAL-1:0] r;
        r = {16'($urandom), 32'($urandom)};
        case ($urandom_range(0, 3))
            0: r = '0;
            1: r = SAT48;
            2: r = r >> $urandom_range(0, 47);
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [W_POS-1:0] pick_size();
        case ($urandom_range(0, 9))
            0: return 0;
            9: return W_POS'($urandom_range(4, 6));
            default: return W_POS'($urandom_range(1, 3));
        endcase
    endfunction

    function automatic cell_t random_cell();
        return cell_of(pick_velocity(), pick_velocity(), pick_velocity(), pick_velocity(),
                       pick_velocity(), pick_velocity(), pick_spacing());
    endfunction

    task automatic write_reg(input logic [W_IDX-1:0] idx, input logic [W_VAL-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_MODE:      cfg_mode = val[0];
            REG_INV_DX:    cfg_inv_dx = val[31:0];
            REG_INV_DY:    cfg_inv_dy = val[31:0];
            REG_TIME_STEP: cfg_time_step = val[31:0];
            REG_LIMIT:     cfg_limit = val;
            REG_SIZE_X:    cfg_size_x = val[W_POS-1:0];
            REG_SIZE_Y:    cfg_size_y = val[W_POS-1:0];
            REG_SIZE_Z:    cfg_size_z = val[W_POS-1:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic mode, input logic [31:0] dx, dy, ts,
                                 input logic [W_VAL-1:0] lim,
                                 input logic [W_POS-1:0] sx, sy, sz);
        write_reg(REG_MODE, mode);
        write_reg(REG_INV_DX, dx);
        write_reg(REG_INV_DY, dy);
        write_reg(REG_TIME_STEP, ts);
        write_reg(REG_LIMIT, lim);
        write_reg(REG_SIZE_X, sx);
        write_reg(REG_SIZE_Y, sy);
        write_reg(REG_SIZE_Z, sz);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    // A phase is over once every cell is taken and every maximum has come back; the extra
    // cycles cover a trailing cell that reports nothing but may still be in flight.
    task automatic drain();
        while (cells_to_send.size() != 0 || i_s_axis_tvalid || maxima_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (20) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : feed
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                scan_cell(cell_t'(i_s_axis_tdata));
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (cells_to_send.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    i_s_axis_tdata <= cells_to_send.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : observe
        max_report_t want;
        max_report_t got;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            hold_cycles <= 0;
            squeezed <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = o_m_axis_tdata[$bits(max_report_t)-1:0];
                if (maxima_due.size() == 0) begin
                    $display("%0t: result with none expected: value=%h i=%0d j=%0d k=%0d passed=%0b",
                             $time, got.value, got.i, got.j, got.k, got.passed);
                    fail_count++;
                end else begin
                    want = maxima_due.pop_front();
                    if (got.value !== want.value || got.i !== want.i || got.j !== want.j ||
                        got.k !== want.k || got.passed !== want.passed) begin
                        $display("%0t: expected value=%h i=%0d j=%0d k=%0d passed=%0b",
                                 $time, want.value, want.i, want.j, want.k, want.passed);
                        $display("%0t:   actual value=%h i=%0d j=%0d k=%0d passed=%0b",
                                 $time, got.value, got.i, got.j, got.k, got.passed);
                        fail_count++;
                    end
                end
            end
            if (hold_cycles != 0) begin
                hold_cycles <= hold_cycles - 1;
                i_m_axis_tready <= 1'b0;
            end else if (squeeze_out && !squeezed) begin
                squeezed <= 1'b1;
                hold_cycles <= 400;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin : main
        int    phase;
        int    per_grid;
        int    n;
        cell_t zero_cell;
        cell_t peak_cell;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = REG_MODE;
        i_cfg_wdata = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_m_axis_tready = 1'b0;
        idle_pct = 15;
        squeeze_out = 1'b0;
        fail_count = 0;
        cfg_mode = MODE_CFL;
        cfg_inv_dx = ONE_Q16;
        cfg_inv_dy = ONE_Q16;
        cfg_time_step = ONE_Q16;
        cfg_limit = 48'h1_0000;
        cfg_size_x = EXTENT_CAP;
        cfg_size_y = EXTENT_CAP;
        cfg_size_z = EXTENT_CAP;
        restart_scan();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Saturation of the CFL sum and of the time step scaling; zero sizes act as one.
        load_settings(MODE_CFL, MAX32, MAX32, MAX32, SAT48, 0, 0, 0);
        cells_to_send.push_back(cell_of(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                        32'h7FFF_FFFF));
        cells_to_send.push_back(cell_of(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0));
        cells_to_send.push_back(cell_of(0, 0, 0, 0, 0, 0, MAX32));
        cells_to_send.push_back(cell_of(32'h7FFF_FFFF, 32'h8000_0000, 1, 0,
                                        MAX32, MAX32, 1));
        cells_to_send.push_back(cell_of(MAX32, 0, 32'h8000_0000, 32'h7FFF_FFFF,
                                        1, MAX32, MAX32));
        drain();

        // Divergence extremes and floor rounding of negative terms.
        load_settings(MODE_DIV, MAX32, 1, 0, 0, 1, 1, 1);
        cells_to_send.push_back(cell_of(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, MAX32));
        cells_to_send.push_back(cell_of(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, MAX32));
        cells_to_send.push_back(cell_of(0, 0, 0, 1, 0, 0, 0));
        cells_to_send.push_back(cell_of(1, 0, 0, 0, 0, 1, 0));
        cells_to_send.push_back(cell_of(0, 0, 0, 0, 0, 0, 0));
        drain();

        // A maximum equal to the limit passes, one step above fails.
        load_settings(MODE_DIV, ONE_Q16, ONE_Q16, ONE_Q16, 48'h1_0000, 1, 1, 1);
        cells_to_send.push_back(cell_of(ONE_Q16, 0, 0, 0, 0, 0, ONE_Q16));
        cells_to_send.push_back(cell_of(ONE_Q16 + 1, 0, 0, 0, 0, 0, ONE_Q16));
        cells_to_send.push_back(cell_of(ONE_Q16, 0, 0, ONE_Q16, 0, 0, ONE_Q16));
        drain();

        // A tie keeps the first position; a zero time step gives a zero CFL result.
        load_settings(MODE_CFL, ONE_Q16, ONE_Q16, 0, 0, 3, 2, 1);
        zero_cell = cell_of(0, 0, 0, 0, 0, 0, 0);
        peak_cell = cell_of(32'h0004_0000, 0, 0, 0, 0, 0, 0);
        cells_to_send.push_back(zero_cell);
        cells_to_send.push_back(peak_cell);
        cells_to_send.push_back(peak_cell);
        cells_to_send.push_back(zero_cell);
        cells_to_send.push_back(cell_of(ONE_Q16, 0, 0, 0, 0, 0, 0));
        cells_to_send.push_back(zero_cell);
        drain();

        // Random phases; some end part way through a grid so that the next settings
        // take effect in the middle of a scan.
        phase = 0;
        n = 0;
        while (n < 800) begin
            idle_pct = (phase % 4 == 3) ? 0 : 15;
            if (phase == 2) begin
                load_settings(1'($urandom_range(0, 1)), pick_spacing(), pick_spacing(),
                              pick_spacing(), pick_limit(), 0, 1, 0);
                idle_pct = 0;
                squeeze_out = 1'b1;
                per_grid = 40;
            end else if (phase == 5) begin
                load_settings(1'($urandom_range(0, 1)), pick_spacing(), pick_spacing(),
                              pick_spacing(), pick_limit(), 2047, 0, 1);
                per_grid = 300;
            end else begin
                load_settings(1'($urandom_range(0, 1)), pick_spacing(), pick_spacing(),
                              pick_spacing(), pick_limit(), pick_size(), pick_size(),
                              pick_size());
                per_grid = extent(cfg_size_x) * extent(cfg_size_y) * extent(cfg_size_z);
                per_grid = per_grid * $urandom_range(1, 5)
                         + (($urandom_range(0, 2) == 0) ? $urandom_range(1, per_grid) : 0);
            end
            if (n + per_grid > 850) begin
                per_grid = 850 - n;
            end
            repeat (per_grid) cells_to_send.push_back(random_cell());
            n += per_grid;
            drain();
            phase++;
        end

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
